### design/interval_range_map_assert.svh
// Assertion macros for the checker file of the interval range map.
`ifndef INTERVAL_RANGE_MAP_ASSERT_SVH
`define INTERVAL_RANGE_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define IRM_AST_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define IRM_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/irm_pkg.sv
// ----------------------------------------------------------------------------
// irm_pkg
// Shared constants and types of the interval range map.
// ----------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_KEY_WIDTH   = 16;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam logic MODE_ASSIGN = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Control from the sequencer to the canonicalizer
  typedef struct packed {
    logic init;
    logic emit;
  } irm_canon_ctl_t;

endpackage

`default_nettype wire

### design/irm_table.sv
// ----------------------------------------------------------------------------
// irm_table
// Two-bank breakpoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_table #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                             clk,
  input  wire                             wr_en,
  input  wire [$clog2(CAPACITY):0]        wr_addr,
  input  wire [KEY_WIDTH-1:0]             wr_key,
  input  wire [VALUE_WIDTH-1:0]           wr_val,
  input  wire                             rd_en,
  input  wire [$clog2(CAPACITY):0]        rd_addr,
  output logic [KEY_WIDTH-1:0]            rd_key,
  output logic [VALUE_WIDTH-1:0]          rd_val
);
  import irm_pkg::*;

  localparam int DEPTH = 2 * (1 << $clog2(CAPACITY));

  logic [KEY_WIDTH-1:0]   mem_key [DEPTH];
  logic [VALUE_WIDTH-1:0] mem_val [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_val[wr_addr] <= wr_val;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_val <= mem_val[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/irm_canon.sv
// ----------------------------------------------------------------------------
// irm_canon
// Canonicalizer: keeps only breakpoints that change the value and counts them.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_canon #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  irm_pkg::irm_canon_ctl_t              ctl,
  input  wire [VALUE_WIDTH-1:0]                dflt,
  input  wire [KEY_WIDTH-1:0]                  emit_key,
  input  wire [VALUE_WIDTH-1:0]                emit_val,
  output logic                                 wr_en,
  output logic [$clog2(CAPACITY)-1:0]          wr_idx,
  output logic [KEY_WIDTH-1:0]                 wr_key,
  output logic [VALUE_WIDTH-1:0]               wr_val,
  output logic [$clog2(CAPACITY+3)-1:0]        fill
);
  import irm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int MW = $clog2(CAPACITY + 3);

  logic [VALUE_WIDTH-1:0] prev;
  logic                   change;

  // Keep an entry only when its value differs from the last kept one
  always_comb begin
    change = ctl.emit && (emit_val != prev);
    wr_en  = change && (fill < MW'(CAPACITY));
    wr_idx = fill[AW-1:0];
    wr_key = emit_key;
    wr_val = emit_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.init) begin
      fill <= '0;
    end else if (change) begin
      fill <= fill + MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      prev <= dflt;
    end else if (change) begin
      prev <= emit_val;
    end
  end

endmodule

`default_nettype wire

### design/interval_range_map.sv
// ----------------------------------------------------------------------------
// interval_range_map
// Piecewise-constant key-to-value map held as sorted breakpoints; lookup and
// range assign with canonical merging, under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  in      | in_valid/in_ready, mode, key_*, new_value | lookup or assign
//  out     | out_valid/out_ready, mapped_value, ...    | one result per item
//  cfg     | cfg_valid/cfg_ready, cfg_data             | default value write
//
// Lookup scans the breakpoint store once, assign scans it twice; each scan
// goes through the single read port of the breakpoint store, streamed one
// entry a cycle. An empty assign range skips the scans.
// A new item is taken while the previous result waits on out_ready.
// Reset clears the breakpoint count; the store itself needs no clearing.
`default_nettype none

module interval_range_map #(
  parameter int CAPACITY    = irm_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = irm_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = irm_pkg::DEF_VALUE_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [VALUE_WIDTH-1:0]            cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              mode,
  input  wire [KEY_WIDTH-1:0]              key_begin,
  input  wire [KEY_WIDTH-1:0]              key_end,
  input  wire [VALUE_WIDTH-1:0]            new_value,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [VALUE_WIDTH-1:0]           mapped_value,
  output logic                             status,
  output logic [$clog2(CAPACITY+1)-1:0]    entries_used
);
  import irm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = $clog2(CAPACITY + 3);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCANA = 3'd1;
  localparam logic [2:0] S_EMITB = 3'd2;
  localparam logic [2:0] S_EMITE = 3'd3;
  localparam logic [2:0] S_SCANB = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]             state;
  logic [VALUE_WIDTH-1:0] dflt;
  logic [CW-1:0]          count;
  logic                   bank;
  logic                   mode_q;
  logic                   empty_q;
  logic [KEY_WIDTH-1:0]   kb_q;
  logic [KEY_WIDTH-1:0]   ke_q;
  logic [VALUE_WIDTH-1:0] nv_q;
  logic [VALUE_WIDTH-1:0] found;
  logic [CW-1:0]          rd_idx;
  logic                   pend;
  logic                   issue;
  logic                   scanning;
  logic                   scan_done;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [KEY_WIDTH-1:0]   probe;
  logic                   in_fire;
  logic                   out_load;
  logic                   full;

  irm_canon_ctl_t         cctl;
  logic [KEY_WIDTH-1:0]   emit_key;
  logic [VALUE_WIDTH-1:0] emit_val;
  logic                   wr_en;
  logic [AW-1:0]          wr_idx;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [MW-1:0]          fill;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Hold the default value
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt <= '0;
    end else if (cfg_valid) begin
      dflt <= cfg_data;
    end
  end

  // Stream the live bank one entry a cycle
  always_comb begin
    scanning  = (state == S_SCANA) || (state == S_SCANB);
    issue     = scanning && (rd_idx < count);
    scan_done = scanning && !issue && !pend;
    probe     = (mode_q == MODE_LOOKUP) ? kb_q : ke_q;
    full      = fill > MW'(CAPACITY);
  end

  // Route emitted breakpoints to the canonicalizer
  always_comb begin
    cctl.init = in_fire;
    cctl.emit = 1'b0;
    emit_key  = rd_key;
    emit_val  = rd_val;
    case (state)
      S_SCANA: cctl.emit = pend && (mode_q == MODE_ASSIGN) && (rd_key < kb_q);
      S_EMITB: begin
        cctl.emit = 1'b1;
        emit_key  = kb_q;
        emit_val  = nv_q;
      end
      S_EMITE: begin
        cctl.emit = 1'b1;
        emit_key  = ke_q;
        emit_val  = found;
      end
      S_SCANB: cctl.emit = pend && (rd_key > ke_q);
      default: cctl.emit = 1'b0;
    endcase
  end

  irm_canon #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_canon (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cctl),
    .dflt    (dflt),
    .emit_key(emit_key),
    .emit_val(emit_val),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .fill    (fill)
  );

  irm_table #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr({~bank, wr_idx}),
    .wr_key (wr_key),
    .wr_val (wr_val),
    .rd_en  (issue),
    .rd_addr({bank, rd_idx[AW-1:0]}),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  // Latch the item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q  <= mode;
      empty_q <= (mode == MODE_ASSIGN) && (key_begin >= key_end);
      kb_q    <= key_begin;
      ke_q    <= key_end;
      nv_q    <= new_value;
    end
  end

  // Track the value at the probe key during the first pass
  always_ff @(posedge clk) begin
    if (in_fire) begin
      found <= dflt;
    end else if ((state == S_SCANA) && pend && (rd_key <= probe)) begin
      found <= rd_val;
    end
  end

  // Advance the read stream
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
    end else if (!scanning) begin
      rd_idx <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // Sequencer and table commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bank  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if ((mode == MODE_ASSIGN) && (key_begin >= key_end)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCANA;
            end
          end
        end
        S_SCANA: begin
          if (scan_done) begin
            state <= (mode_q == MODE_LOOKUP) ? S_FIN : S_EMITB;
          end
        end
        S_EMITB: state <= S_EMITE;
        S_EMITE: state <= S_SCANB;
        S_SCANB: begin
          if (scan_done) begin
            state <= S_FIN;
            if (!full) begin
              bank  <= ~bank;
              count <= fill[CW-1:0];
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      entries_used <= count;
      if (mode_q == MODE_LOOKUP) begin
        mapped_value <= found;
        status       <= STATUS_DONE;
      end else begin
        mapped_value <= '0;
        status       <= (!empty_q && full) ? STATUS_FULL : STATUS_DONE;
      end
    end
  end

endmodule

`default_nettype wire

### design/irm_checker.sv
// ----------------------------------------------------------------------------
// irm_checker
// Port-level checks of the interval range map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interval_range_map_assert.svh"

module irm_checker #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input wire                           clk,
  input wire                           rst,
  input wire                           cfg_valid,
  input wire                           cfg_ready,
  input wire [VALUE_WIDTH-1:0]         cfg_data,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           mode,
  input wire [KEY_WIDTH-1:0]           key_begin,
  input wire [KEY_WIDTH-1:0]           key_end,
  input wire [VALUE_WIDTH-1:0]         new_value,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [VALUE_WIDTH-1:0]         mapped_value,
  input wire                           status,
  input wire [$clog2(CAPACITY+1)-1:0]  entries_used
);
  import irm_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  `IRM_AST_SAME(a_count_bound, out_valid, entries_used <= CW'(CAPACITY), "count over capacity")
  `IRM_AST_SAME(a_full_zero, out_valid && (status == STATUS_FULL), mapped_value == '0, "full with value")
  `IRM_AST_NEXT(a_busy, in_valid && in_ready, !in_ready, "took two items at once")
  `IRM_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mapped_value), "result dropped")

endmodule

bind interval_range_map irm_checker #(
  .CAPACITY   (CAPACITY),
  .KEY_WIDTH  (KEY_WIDTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_irm_checker (.*);

`default_nettype wire
